/* rtl/fdf_pkg.sv */
// Shared types and constants of the sync/length/Fletcher-16 frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package fdf_pkg;

    // Sync pattern and framing constants.
    localparam logic [7:0]  SYNC_FIRST   = 8'hC0;
    localparam logic [7:0]  SYNC_SECOND  = 8'h3E;
    localparam logic [8:0]  FLETCHER_MOD = 9'd255;

    // Frame positions; the payload starts after the four header bytes.
    localparam logic [12:0] POS_HUNT     = 13'd0;
    localparam logic [12:0] POS_SYNC     = 13'd1;
    localparam logic [12:0] POS_LEN_HI   = 13'd2;
    localparam logic [12:0] POS_LEN_LO   = 13'd3;
    localparam logic [12:0] HEADER_BYTES = 13'd4;

    // Reset value of the payload length limit.
    localparam logic [11:0] MAX_LEN_RESET = 12'd256;

    // Event codes of a result.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PAYLOAD  = 3'd1;
    localparam logic [2:0] EV_GOOD     = 3'd2;
    localparam logic [2:0] EV_LENGTH   = 3'd3;
    localparam logic [2:0] EV_CHECKSUM = 3'd4;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Class of a request as decided by the front.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_LOST = 2'd1,
        KIND_SKIP = 2'd2
    } t_kind;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic [1:0] channel;
        logic [7:0] data;
        logic       is_sync1;
        logic       is_sync2;
    } t_item;

endpackage

`default_nettype wire

/* rtl/fletcher16_frame_deframer.sv */
// Top level of the per-channel sync/length/Fletcher-16 byte deframer.
//
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_ready   i_opcode, i_channel, i_data_byte
//  result    out        o_valid / i_ready   o_out_channel, o_event_res, o_payload_byte,
//                                           o_payload_length, four 32-bit counters
//  config    in         i_cfg_wr_en         i_cfg_wr_data (payload length limit)
//
// One request is taken per clock cycle while o_ready is high, and every request gives
// exactly one result. A request is captured in the front register when it is accepted,
// then written into the two-entry queue, and from there loaded into the result register.
// The back stage updates a channel's state as it takes the request, so requests for the
// same channel may follow each other with no gap. When the result side stalls, the queue
// and the front register fill before o_ready falls. Reset is synchronous and active low;
// it clears every channel to hunting, zeroes the counters and sets the limit to 256.
`timescale 1ns / 1ps
`default_nettype none

module fletcher16_frame_deframer #(
    parameter int CHANNELS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [11:0] i_cfg_wr_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_opcode,
    input  wire  [1:0]  i_channel,
    input  wire  [7:0]  i_data_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_out_channel,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [11:0] o_payload_length,
    output logic [31:0] o_parse_error_count,
    output logic [31:0] o_checksum_error_count,
    output logic [31:0] o_frame_count,
    output logic [31:0] o_byte_count
);

    // Classified requests between the front and the queue.
    logic           fe_valid;
    logic           fe_ready;
    fdf_pkg::t_item fe_item;

    // Requests leaving the queue for the back stage.
    logic           q_valid;
    logic           q_ready;
    fdf_pkg::t_item q_item;

    // The front registers each request and decides whether it is a data byte,
    // a connection loss, or a request for a channel that does not exist. It
    // also flags the two sync byte values so the back stage need not compare.
    fdf_front #(
        .CHANNELS     (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_channel    (i_channel),
        .i_data_byte  (i_data_byte),
        .o_push_valid (fe_valid),
        .i_push_ready (fe_ready),
        .o_push_item  (fe_item)
    );

    // The queue lets the front keep taking requests while the result side is
    // stalled, until the queue and the front register are full.
    fdf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_item  (fe_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    // The back stage holds the per-channel frame position, length and running
    // Fletcher sums, the global counters and the length limit. It advances one
    // channel per request and loads the result register in the same cycle; the
    // counters are shown straight from their registers, which only move when a
    // new result is loaded, so they always match the result on display.
    fdf_back #(
        .CHANNELS               (CHANNELS)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_wr_data          (i_cfg_wr_data),
        .i_item_valid           (q_valid),
        .o_item_ready           (q_ready),
        .i_item                 (q_item),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_out_channel          (o_out_channel),
        .o_event_res            (o_event_res),
        .o_payload_byte         (o_payload_byte),
        .o_payload_length       (o_payload_length),
        .o_parse_error_count    (o_parse_error_count),
        .o_checksum_error_count (o_checksum_error_count),
        .o_frame_count          (o_frame_count),
        .o_byte_count           (o_byte_count)
    );

endmodule

`default_nettype wire

/* rtl/fdf_front.sv */
// Front stage: accepts requests, classifies them and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none

module fdf_front #(
    parameter int CHANNELS = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_opcode,
    input  wire  [1:0]        i_channel,
    input  wire  [7:0]        i_data_byte,
    output logic              o_push_valid,
    input  wire               i_push_ready,
    output fdf_pkg::t_item    o_push_item
);

    logic           r_valid;
    fdf_pkg::t_item r_item;
    fdf_pkg::t_item n_item;
    logic           accept;

    assign o_ready = !r_valid || i_push_ready;
    assign accept  = i_valid && o_ready;

    // Channels beyond the configured count are passed on as no-ops.
    always_comb begin
        n_item.channel  = i_channel;
        n_item.data     = i_data_byte;
        n_item.is_sync1 = (i_data_byte == fdf_pkg::SYNC_FIRST);
        n_item.is_sync2 = (i_data_byte == fdf_pkg::SYNC_SECOND);
        if (5'(i_channel) >= 5'(CHANNELS)) begin
            n_item.kind = fdf_pkg::KIND_SKIP;
        end else if (i_opcode) begin
            n_item.kind = fdf_pkg::KIND_LOST;
        end else begin
            n_item.kind = fdf_pkg::KIND_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

endmodule

`default_nettype wire

/* rtl/fdf_queue.sv */
// Short FIFO that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none

module fdf_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  wire fdf_pkg::t_item i_push_item,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output fdf_pkg::t_item      o_pop_item
);

    localparam int DEPTH = fdf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fdf_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/fdf_back.sv */
// Back stage: per-channel framing state, Fletcher-16 sums, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module fdf_back #(
    parameter int CHANNELS = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire  [11:0]         i_cfg_wr_data,
    input  wire                 i_item_valid,
    output logic                o_item_ready,
    input  wire fdf_pkg::t_item i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [1:0]          o_out_channel,
    output logic [2:0]          o_event_res,
    output logic [7:0]          o_payload_byte,
    output logic [11:0]         o_payload_length,
    output logic [31:0]         o_parse_error_count,
    output logic [31:0]         o_checksum_error_count,
    output logic [31:0]         o_frame_count,
    output logic [31:0]         o_byte_count
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Per-channel state.
    logic [12:0] r_pos   [CHANNELS];
    logic [15:0] r_len   [CHANNELS];
    logic [7:0]  r_sum_lo[CHANNELS];
    logic [7:0]  r_sum_hi[CHANNELS];
    logic [7:0]  r_chk_hi[CHANNELS];

    logic [11:0] r_max_len;
    logic [31:0] r_parse_errs;
    logic [31:0] r_cksum_errs;
    logic [31:0] r_good_frames;
    logic [31:0] r_good_bytes;

    logic        r_out_valid;
    logic [1:0]  r_out_channel;
    logic [2:0]  r_out_event;
    logic [7:0]  r_out_byte;
    logic [11:0] r_out_length;

    logic             take;
    logic             wr_en;
    logic [4:0]       ch_ext;
    logic [IDX_W-1:0] idx;

    logic [12:0] pos;
    logic [15:0] len;
    logic [7:0]  sum_lo;
    logic [7:0]  sum_hi;
    logic [7:0]  chk_hi;
    logic [15:0] full_len;
    logic [12:0] end_pos;
    logic [8:0]  sum1_raw;
    logic [7:0]  sum1;
    logic [8:0]  sum2_raw;
    logic [7:0]  sum2;

    logic [12:0] n_pos;
    logic [15:0] n_len;
    logic [7:0]  n_sum_lo;
    logic [7:0]  n_sum_hi;
    logic [7:0]  n_chk_hi;
    logic [2:0]  n_event;
    logic [7:0]  n_byte;
    logic [11:0] n_length;
    logic        inc_parse;
    logic        inc_cksum;
    logic        inc_good;

    assign o_item_ready = !r_out_valid || i_ready;
    assign take         = i_item_valid && o_item_ready;
    assign wr_en        = (i_item.kind != fdf_pkg::KIND_SKIP);
    assign ch_ext       = 5'(i_item.channel);
    assign idx          = ch_ext[IDX_W-1:0];

    assign pos    = r_pos[idx];
    assign len    = r_len[idx];
    assign sum_lo = r_sum_lo[idx];
    assign sum_hi = r_sum_hi[idx];
    assign chk_hi = r_chk_hi[idx];

    assign full_len = {len[15:8], i_item.data};
    assign end_pos  = 13'(len[11:0]) + fdf_pkg::HEADER_BYTES;

    // Both running sums stay below 255, so one conditional subtract reduces each.
    assign sum1_raw = {1'b0, sum_lo} + {1'b0, i_item.data};
    assign sum1     = (sum1_raw >= fdf_pkg::FLETCHER_MOD) ?
                      8'(sum1_raw - fdf_pkg::FLETCHER_MOD) : sum1_raw[7:0];
    assign sum2_raw = {1'b0, sum_hi} + {1'b0, sum1};
    assign sum2     = (sum2_raw >= fdf_pkg::FLETCHER_MOD) ?
                      8'(sum2_raw - fdf_pkg::FLETCHER_MOD) : sum2_raw[7:0];

    always_comb begin
        n_pos     = pos;
        n_len     = len;
        n_sum_lo  = sum_lo;
        n_sum_hi  = sum_hi;
        n_chk_hi  = chk_hi;
        n_event   = fdf_pkg::EV_NONE;
        n_byte    = '0;
        n_length  = '0;
        inc_parse = 1'b0;
        inc_cksum = 1'b0;
        inc_good  = 1'b0;
        unique case (i_item.kind)
            fdf_pkg::KIND_LOST: begin
                n_pos = fdf_pkg::POS_HUNT;
            end
            fdf_pkg::KIND_BYTE: begin
                priority if (pos == fdf_pkg::POS_HUNT) begin
                    if (i_item.is_sync1) begin
                        n_pos = fdf_pkg::POS_SYNC;
                    end
                end else if (pos == fdf_pkg::POS_SYNC) begin
                    if (i_item.is_sync2) begin
                        n_pos = fdf_pkg::POS_LEN_HI;
                    end else if (!i_item.is_sync1) begin
                        n_pos = fdf_pkg::POS_HUNT;
                    end
                end else if (pos == fdf_pkg::POS_LEN_HI) begin
                    n_len = {i_item.data, 8'h00};
                    n_pos = fdf_pkg::POS_LEN_LO;
                end else if (pos == fdf_pkg::POS_LEN_LO) begin
                    n_len = full_len;
                    if (full_len > {4'h0, r_max_len}) begin
                        inc_parse = 1'b1;
                        n_pos     = fdf_pkg::POS_HUNT;
                        n_event   = fdf_pkg::EV_LENGTH;
                    end else begin
                        n_sum_lo = '0;
                        n_sum_hi = '0;
                        n_pos    = fdf_pkg::HEADER_BYTES;
                    end
                end else if (pos < end_pos) begin
                    n_sum_lo = sum1;
                    n_sum_hi = sum2;
                    n_pos    = pos + 13'd1;
                    n_event  = fdf_pkg::EV_PAYLOAD;
                    n_byte   = i_item.data;
                end else if (pos == end_pos) begin
                    n_chk_hi = i_item.data;
                    n_pos    = pos + 13'd1;
                end else begin
                    n_pos = fdf_pkg::POS_HUNT;
                    if ((chk_hi == sum_hi) && (i_item.data == sum_lo)) begin
                        inc_good = 1'b1;
                        n_event  = fdf_pkg::EV_GOOD;
                        n_length = len[11:0];
                    end else begin
                        inc_cksum = 1'b1;
                        n_event   = fdf_pkg::EV_CHECKSUM;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c] <= fdf_pkg::POS_HUNT;
            end
        end else if (take && wr_en) begin
            r_pos[idx] <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && wr_en) begin
            r_len[idx]    <= n_len;
            r_sum_lo[idx] <= n_sum_lo;
            r_sum_hi[idx] <= n_sum_hi;
            r_chk_hi[idx] <= n_chk_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= fdf_pkg::MAX_LEN_RESET;
            r_parse_errs  <= '0;
            r_cksum_errs  <= '0;
            r_good_frames <= '0;
            r_good_bytes  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (take) begin
                r_out_valid <= 1'b1;
                if (inc_parse) begin
                    r_parse_errs <= r_parse_errs + 32'd1;
                end
                if (inc_cksum) begin
                    r_cksum_errs <= r_cksum_errs + 32'd1;
                end
                if (inc_good) begin
                    r_good_frames <= r_good_frames + 32'd1;
                    r_good_bytes  <= r_good_bytes + 32'(len[11:0]);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_channel <= i_item.channel;
            r_out_event   <= n_event;
            r_out_byte    <= n_byte;
            r_out_length  <= n_length;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_out_channel          = r_out_channel;
    assign o_event_res            = r_out_event;
    assign o_payload_byte         = r_out_byte;
    assign o_payload_length       = r_out_length;
    assign o_parse_error_count    = r_parse_errs;
    assign o_checksum_error_count = r_cksum_errs;
    assign o_frame_count          = r_good_frames;
    assign o_byte_count           = r_good_bytes;

endmodule

`default_nettype wire

/* rtl/fdf_checker.sv */
// Port-level assertions for the deframer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module fdf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_ready,
    input wire [2:0]  o_event_res,
    input wire [7:0]  o_payload_byte,
    input wire [11:0] o_payload_length,
    input wire [31:0] o_parse_error_count,
    input wire [31:0] o_checksum_error_count,
    input wire [31:0] o_frame_count
);

    // A stalled result keeps its event.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_res))
        else $error("result changed while stalled");

    // The length-error counter moves only together with a length-error result.
    a_parse_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_parse_error_count) |-> o_valid && (o_event_res == fdf_pkg::EV_LENGTH))
        else $error("length error count moved without a length error");

    // The checksum-error counter moves only together with a checksum-error result.
    a_cksum_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_checksum_error_count) |->
            o_valid && (o_event_res == fdf_pkg::EV_CHECKSUM))
        else $error("checksum error count moved without a checksum error");

    // The good-frame counter moves only together with a frame-good result.
    a_frame_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_frame_count) |-> o_valid && (o_event_res == fdf_pkg::EV_GOOD))
        else $error("frame count moved without a good frame");

    // Length and byte fields are zero unless the event carries them.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_event_res == fdf_pkg::EV_GOOD) || (o_payload_length == 12'd0)) &&
                    ((o_event_res == fdf_pkg::EV_PAYLOAD) || (o_payload_byte == 8'd0)))
        else $error("payload field set for the wrong event");

endmodule

bind fletcher16_frame_deframer fdf_checker u_fdf_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_valid                (o_valid),
    .i_ready                (i_ready),
    .o_event_res            (o_event_res),
    .o_payload_byte         (o_payload_byte),
    .o_payload_length       (o_payload_length),
    .o_parse_error_count    (o_parse_error_count),
    .o_checksum_error_count (o_checksum_error_count),
    .o_frame_count          (o_frame_count)
);

`default_nettype wire
